[hdl/vertex_dedup_normal_accumulator_defines.svh]
// Assertion macros for the checker file of the vertex dedup block.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef VERTEX_DEDUP_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_DEDUP_NORMAL_ACCUMULATOR_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define VDNA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal holds its value into the cycle after a condition.
`define VDNA_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

[hdl/vdna_pkg.sv]
// Shared types, sizes and helpers for the vertex dedup / normal accumulator.
// Used by every module of the block.
package vdna_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HASH_W      = IDX_W + 1;
    localparam int HASH_DEPTH  = 2 ** HASH_W;
    localparam int VIDX_W      = 10;
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = 1;
    localparam int DIV_STEPS   = 32;
    localparam int DCNT_W      = $clog2(DIV_STEPS);

    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_READ   = 1'b1;
    localparam logic [15:0] FACE_MAX  = 16'hFFFF;

    typedef struct packed {
        logic                     cmd;
        logic [2:0][31:0]         key;
        logic [2:0][15:0]         nrm;
        logic [VIDX_W-1:0]        read_index;
    } item_t;

    typedef struct packed {
        logic                     used;
        logic [2:0][31:0]         key;
        logic [IDX_W-1:0]         idx;
    } slot_t;

    typedef struct packed {
        logic [2:0][31:0]         pos;
        logic [2:0][31:0]         sums;
        logic [15:0]              faces;
    } entry_t;

    typedef struct packed {
        logic [VIDX_W-1:0]        entry_idx;
        logic                     is_new;
        logic                     overflow;
        logic [2:0][31:0]         pos;
        logic [2:0][15:0]         avg;
        logic [15:0]              face_count;
    } result_t;

    // Negative zero folds onto positive zero.
    function automatic logic [31:0] canon(input logic [31:0] b);
        return (b == 32'h8000_0000) ? 32'h0 : b;
    endfunction

    function automatic logic [HASH_W-1:0] key_hash(input logic [2:0][31:0] key);
        logic [31:0]       m;
        logic [HASH_W-1:0] h;
        m = key[0] ^ {key[1][20:0], key[1][31:21]} ^ {key[2][9:0], key[2][31:10]};
        m = m ^ {16'h0, m[31:16]} ^ {m[6:0], 25'h0};
        h = '0;
        for (int i = 0; i < 32; i++)
        begin
            h[i % HASH_W] = h[i % HASH_W] ^ m[i];
        end
        return h;
    endfunction

endpackage

[hdl/vertex_dedup_normal_accumulator.sv]
// Vertex dedup and normal accumulator. Insert beats (cmd 0) look the canonical
// position up in a linear-probed hash table of 2048 slots; a new position takes
// the next free index, and the face normal is summed into the entry with a
// saturating face count. Read beats (cmd 1) return the stored position and the
// normal average, rounded half away from zero and clamped. After reset a
// clearing pass sweeps all 2048 hash slots while in_ready stays low.
// One item is worked at a time: an insert probes the hash table, stepping to
// the next slot on each hash collision, and reads and updates a stored entry
// before output; a read of a used entry runs the bit-serial divider once per
// normal component, and a read of an unused entry is flagged overflow, as is
// an insert into a full table. A two-beat queue in front and an output
// register let input and output stall apart.
module vertex_dedup_normal_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic signed [15:0] face_nx,
    input  logic signed [15:0] face_ny,
    input  logic signed [15:0] face_nz,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  entry_idx,
    output logic        is_new,
    output logic        overflow,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic signed [15:0] avg_nx,
    output logic signed [15:0] avg_ny,
    output logic signed [15:0] avg_nz,
    output logic [15:0] face_count
);

    logic               push, q_full, q_valid, pop, clearing;
    vdna_pkg::item_t    push_item, q_item;
    vdna_pkg::result_t  res;

    vdna_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .face_nx    (face_nx),
        .face_ny    (face_ny),
        .face_nz    (face_nz),
        .read_index (read_index),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_item  (push_item)
    );

    vdna_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_item    (q_item)
    );

    vdna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign entry_idx    = res.entry_idx;
    assign is_new       = res.is_new;
    assign overflow     = res.overflow;
    assign out_x        = res.pos[0];
    assign out_y        = res.pos[1];
    assign out_z        = res.pos[2];
    assign avg_nx       = res.avg[0];
    assign avg_ny       = res.avg[1];
    assign avg_nz       = res.avg[2];
    assign face_count   = res.face_count;

endmodule

[hdl/vdna_fifo.sv]
// Two-entry item queue between the front and back parts.
// Depends on vdna_pkg.
module vdna_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vdna_pkg::item_t push_item,
    output logic           full,
    output logic           q_valid,
    input  logic           pop,
    output vdna_pkg::item_t q_item
);

    vdna_pkg::item_t mem [vdna_pkg::FIFO_DEPTH];
    logic [vdna_pkg::FPTR_W-1:0] wr_reg, rd_reg;
    logic [vdna_pkg::FPTR_W:0]   cnt_reg;

    assign full    = (cnt_reg == (vdna_pkg::FPTR_W + 1)'(vdna_pkg::FIFO_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/vdna_front.sv]
// Input side: takes beats, canonicalizes positions and forms queue items.
// Depends on vdna_pkg.
module vdna_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            cmd,
    input  logic [31:0]     pos_x,
    input  logic [31:0]     pos_y,
    input  logic [31:0]     pos_z,
    input  logic [15:0]     face_nx,
    input  logic [15:0]     face_ny,
    input  logic [15:0]     face_nz,
    input  logic [9:0]      read_index,
    input  logic            q_full,
    input  logic            clearing,
    output logic            push,
    output vdna_pkg::item_t push_item
);

    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_item            = '0;
        push_item.cmd        = cmd;
        push_item.read_index = read_index;
        if (cmd == vdna_pkg::CMD_INSERT)
        begin
            push_item.key[0] = vdna_pkg::canon(pos_x);
            push_item.key[1] = vdna_pkg::canon(pos_y);
            push_item.key[2] = vdna_pkg::canon(pos_z);
            push_item.nrm[0] = face_nx;
            push_item.nrm[1] = face_ny;
            push_item.nrm[2] = face_nz;
        end
    end

endmodule

[hdl/vdna_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned.
// Depends on vdna_pkg.
module vdna_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic                      busy_reg, done_reg;
    logic [vdna_pkg::DCNT_W-1:0] cnt_reg;
    logic [15:0]               rem_reg, dvs_reg;
    logic [31:0]               quo_reg;
    logic [16:0]               trial, diff;

    assign trial    = {rem_reg, quo_reg[31]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[16])
            begin
                rem_reg <= diff[15:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vdna_pkg::DCNT_W'(vdna_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/vdna_back.sv]
// Back part: hash probe, entry read-modify-write, averaging and result register.
// Depends on vdna_pkg and vdna_div.
module vdna_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  vdna_pkg::item_t  q_item,
    output logic             pop,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_ready,
    output vdna_pkg::result_t out_res
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_PROBE  = 8'b0000_0100,
        ST_UPD    = 8'b0000_1000,
        ST_RDW    = 8'b0001_0000,
        ST_DSTART = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [vdna_pkg::HASH_W-1:0] slot_reg, slot_next, clr_reg, clr_next;
    logic [vdna_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [vdna_pkg::CNT_W-1:0]  free_reg, free_next;
    logic [1:0]                  comp_reg, comp_next;
    logic                        sign_reg, sign_next;
    vdna_pkg::item_t             item_reg, item_next;
    vdna_pkg::entry_t            entry_reg, entry_next;
    vdna_pkg::result_t           res_reg, res_next, out_reg;
    logic                        out_valid_reg, load_out;

    vdna_pkg::slot_t             hash_mem [vdna_pkg::HASH_DEPTH];
    vdna_pkg::slot_t             hash_rdata_reg, hash_wdata;
    logic [vdna_pkg::HASH_W-1:0] hash_raddr, hash_waddr;
    logic                        hash_we;

    vdna_pkg::entry_t            ent_mem [vdna_pkg::TABLE_DEPTH];
    vdna_pkg::entry_t            ent_rdata_reg, ent_wdata;
    logic [vdna_pkg::IDX_W-1:0]  ent_raddr, ent_waddr;
    logic                        ent_we;

    logic                        div_start, div_done;
    logic [31:0]                 div_dividend, div_q, sum_sel, mag;

    vdna_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (entry_reg.faces),
        .done     (div_done),
        .quotient (div_q)
    );

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Magnitude plus half the count gives round-half-away after truncation.
    assign sum_sel      = entry_reg.sums[comp_reg];
    assign mag          = sum_sel[31] ? (~sum_sel + 32'd1) : sum_sel;
    assign div_dividend = mag + {17'h0, entry_reg.faces[15:1]};

    always_ff @(posedge clk)
    begin
        if (hash_we)
        begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        hash_rdata_reg <= hash_mem[hash_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    always_comb
    begin
        vdna_pkg::slot_t  s;
        vdna_pkg::entry_t e;
        state_next = state_reg;
        slot_next  = slot_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        free_next  = free_reg;
        comp_next  = comp_reg;
        sign_next  = sign_reg;
        item_next  = item_reg;
        entry_next = entry_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        hash_we    = 1'b0;
        hash_waddr = slot_reg;
        hash_wdata = '0;
        hash_raddr = slot_reg;
        ent_we     = 1'b0;
        ent_waddr  = idx_reg;
        ent_wdata  = ent_rdata_reg;
        ent_raddr  = idx_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        s          = hash_rdata_reg;
        e          = ent_rdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                hash_we    = 1'b1;
                hash_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == {vdna_pkg::HASH_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    item_next = q_item;
                    res_next  = '0;
                    if (q_item.cmd == vdna_pkg::CMD_READ)
                    begin
                        res_next.entry_idx = q_item.read_index;
                        ent_raddr = vdna_pkg::IDX_W'(q_item.read_index);
                        if (vdna_pkg::CNT_W'(q_item.read_index) < free_reg)
                        begin
                            state_next = ST_RDW;
                        end
                        else
                        begin
                            res_next.overflow = 1'b1;
                            state_next        = ST_OUT;
                        end
                    end
                    else
                    begin
                        hash_raddr = vdna_pkg::key_hash(q_item.key);
                        slot_next  = hash_raddr;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (s.used && s.key == item_reg.key)
                begin
                    idx_next   = s.idx;
                    ent_raddr  = s.idx;
                    state_next = ST_UPD;
                end
                else if (s.used)
                begin
                    // Linear probe: advance to the next slot.
                    slot_next  = slot_reg + 1'b1;
                    hash_raddr = slot_reg + 1'b1;
                end
                else if (free_reg == vdna_pkg::CNT_W'(vdna_pkg::TABLE_DEPTH))
                begin
                    res_next.overflow = 1'b1;
                    state_next        = ST_OUT;
                end
                else
                begin
                    hash_we         = 1'b1;
                    hash_wdata.used = 1'b1;
                    hash_wdata.key  = item_reg.key;
                    hash_wdata.idx  = vdna_pkg::IDX_W'(free_reg);
                    ent_we          = 1'b1;
                    ent_waddr       = vdna_pkg::IDX_W'(free_reg);
                    ent_wdata.pos   = item_reg.key;
                    for (int k = 0; k < 3; k++)
                    begin
                        ent_wdata.sums[k] = {{16{item_reg.nrm[k][15]}}, item_reg.nrm[k]};
                    end
                    ent_wdata.faces     = 16'd1;
                    free_next           = free_reg + 1'b1;
                    res_next.entry_idx  = vdna_pkg::VIDX_W'(free_reg);
                    res_next.is_new     = 1'b1;
                    res_next.face_count = 16'd1;
                    state_next          = ST_OUT;
                end
            end
            ST_UPD:
            begin
                ent_we    = 1'b1;
                ent_wdata = e;
                if (e.faces != vdna_pkg::FACE_MAX)
                begin
                    ent_wdata.faces = e.faces + 16'd1;
                    for (int k = 0; k < 3; k++)
                    begin
                        ent_wdata.sums[k] = e.sums[k]
                            + {{16{item_reg.nrm[k][15]}}, item_reg.nrm[k]};
                    end
                end
                res_next.entry_idx  = vdna_pkg::VIDX_W'(idx_reg);
                res_next.face_count = ent_wdata.faces;
                state_next          = ST_OUT;
            end
            ST_RDW:
            begin
                entry_next          = e;
                res_next.pos        = e.pos;
                res_next.face_count = e.faces;
                comp_next           = 2'd0;
                state_next          = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                sign_next  = sum_sel[31];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (!sign_reg)
                    begin
                        res_next.avg[comp_reg] = (div_q > 32'd32767) ? 16'h7FFF : div_q[15:0];
                    end
                    else
                    begin
                        res_next.avg[comp_reg] = (div_q > 32'd32768) ? 16'h8000
                                                                      : (~div_q[15:0] + 16'd1);
                    end
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DSTART;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        idx_reg   <= idx_next;
        comp_reg  <= comp_next;
        sign_reg  <= sign_next;
        item_reg  <= item_next;
        entry_reg <= entry_next;
        res_reg   <= res_next;
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hdl/vdna_checker.sv]
// Port-level checks for the vertex dedup block, bound to the top level.
// Depends on vertex_dedup_normal_accumulator_defines.svh.
`include "vertex_dedup_normal_accumulator_defines.svh"

module vdna_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  entry_idx,
    input logic        is_new,
    input logic        overflow,
    input logic [31:0] out_x,
    input logic [15:0] avg_nx,
    input logic [15:0] face_count
);

    logic ovf_clear;

    assign ovf_clear = (face_count == 16'd0) && (out_x == 32'd0) && (avg_nx == 16'd0);

    `VDNA_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, entry_idx, "result moved in stall")
    `VDNA_ASSERT(a_new_not_ovf, out_valid |-> !(is_new && overflow), "new entry flagged overflow")
    `VDNA_ASSERT(a_new_one_face, (out_valid && is_new) |-> (face_count == 16'd1), "new count not 1")
    `VDNA_ASSERT(a_ovf_zero, (out_valid && overflow) |-> ovf_clear, "overflow result not cleared")

endmodule

bind vertex_dedup_normal_accumulator vdna_checker u_vdna_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .entry_idx    (entry_idx),
    .is_new       (is_new),
    .overflow     (overflow),
    .out_x        (out_x),
    .avg_nx       (avg_nx),
    .face_count   (face_count)
);
